>>> rtl/llh_pkg.sv
// Shared constants, codes and controller/datapath link types for the latency histogram.
package llh_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int BIN_COUNT_DEF = 27;
	localparam int OP_TYPES_DEF = 4;

	localparam int CMD_W = 2;
	localparam int ID_W = 32;
	localparam int TS_W = 64;
	localparam int OP_W = 3;
	localparam int HIT_W = 6;
	localparam int CNT32_W = 32;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	// Scale divisors and the width of the shifted threshold compared with the elapsed time.
	localparam int DIV_W = 20;
	localparam logic [DIV_W-1:0] US_DIV = DIV_W'(1000);
	localparam logic [DIV_W-1:0] MS_DIV = DIV_W'(1000000);
	localparam int THR_W = TS_W + DIV_W;

	localparam logic [CMD_W-1:0] CMD_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FINISH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_UNIT_MS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER = 1'd1;

	localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FILTERED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BINNED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_START = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NEGATIVE = 3'd5;
	localparam logic [STATUS_W-1:0] ST_BAD_TYPE = 3'd6;
	localparam logic [STATUS_W-1:0] ST_READ = 3'd7;

	typedef struct packed {
		logic load_item;
		logic scan_run;
		logic wr_entry;
		logic rd_time;
		logic clr_entry;
		logic calc_diff;
		logic log_step;
		logic bin_rd;
		logic bin_wr;
		logic bin_cap;
		logic res_load;
		logic [STATUS_W-1:0] res_code;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] item_cmd;
		logic filtered;
		logic scan_done;
		logic found;
		logic free_found;
		logic negative;
		logic op_bad;
		logic log_done;
		logic rd_in_range;
		logic out_free;
	} ctrl_sts_t;

endpackage

>>> rtl/llh_if.sv
// Item channel interfaces: input events and result items.
interface llh_in_if;
	logic valid;
	logic ready;
	logic [llh_pkg::CMD_W-1:0] command;
	logic [llh_pkg::ID_W-1:0] thread_id;
	logic [llh_pkg::ID_W-1:0] group_id;
	logic [llh_pkg::TS_W-1:0] timestamp_ns;
	logic [llh_pkg::OP_W-1:0] op_type;
	logic [llh_pkg::HIT_W-1:0] bin_index;
	modport source (output valid, command, thread_id, group_id, timestamp_ns, op_type,
		bin_index, input ready);
	modport sink (input valid, command, thread_id, group_id, timestamp_ns, op_type,
		bin_index, output ready);
endinterface

interface llh_out_if;
	logic valid;
	logic ready;
	logic [llh_pkg::STATUS_W-1:0] status;
	logic [llh_pkg::HIT_W-1:0] bin_hit;
	logic [llh_pkg::CNT32_W-1:0] bin_count;
	modport source (output valid, status, bin_hit, bin_count, input ready);
	modport sink (input valid, status, bin_hit, bin_count, output ready);
endinterface

>>> rtl/llh_datapath.sv
// Datapath: start table, thread search, log2 binning, histogram store and result register.
module llh_datapath #(
	parameter int TABLE_DEPTH = llh_pkg::TABLE_DEPTH_DEF,
	parameter int BIN_COUNT = llh_pkg::BIN_COUNT_DEF,
	parameter int OP_TYPES = llh_pkg::OP_TYPES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [llh_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [llh_pkg::CFG_DATA_W-1:0] cfg_data,
	llh_in_if.sink in,
	llh_out_if.source out,
	input llh_pkg::ctrl_cmd_t cmd,
	output llh_pkg::ctrl_sts_t sts
);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int NBINS = OP_TYPES * BIN_COUNT;
	localparam int BADDR_W = (NBINS > 1) ? $clog2(NBINS) : 1;
	localparam int BSUM_W = 10;

	logic unit_ms_q;
	logic [llh_pkg::ID_W-1:0] filter_q;

	logic [llh_pkg::CMD_W-1:0] icmd_q;
	logic [llh_pkg::ID_W-1:0] tid_q;
	logic [llh_pkg::ID_W-1:0] gid_q;
	logic [llh_pkg::TS_W-1:0] ts_q;
	logic [llh_pkg::OP_W-1:0] op_q;
	logic [llh_pkg::HIT_W-1:0] bidx_q;

	logic [llh_pkg::ID_W-1:0] key_mem [TABLE_DEPTH];
	logic [llh_pkg::TS_W-1:0] time_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;

	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx;
	logic issue;
	logic p_s1;
	logic vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [llh_pkg::ID_W-1:0] key_rd_s1;
	logic free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic found_q;
	logic [IDX_W-1:0] ent_q;
	logic match;
	logic last;

	logic [llh_pkg::TS_W-1:0] time_rd_q;
	logic [llh_pkg::TS_W-1:0] diff_q;
	logic [llh_pkg::THR_W-1:0] thr_q;
	logic [llh_pkg::HIT_W-1:0] k_q;
	logic [llh_pkg::DIV_W-1:0] div;

	logic [llh_pkg::CNT32_W-1:0] bin_mem [NBINS];
	logic [NBINS-1:0] bvld_q;
	logic [llh_pkg::HIT_W-1:0] bkey;
	logic [BSUM_W-1:0] bsum;
	logic [BADDR_W-1:0] baddr;
	logic [BADDR_W-1:0] baddr_q;
	logic [llh_pkg::CNT32_W-1:0] bin_rd_s1;
	logic bvld_s1;
	logic [llh_pkg::CNT32_W-1:0] bin_eff;
	logic [llh_pkg::CNT32_W-1:0] bcount_q;

	logic out_valid_q;
	logic [llh_pkg::STATUS_W-1:0] status_q;
	logic [llh_pkg::HIT_W-1:0] hit_q;
	logic [llh_pkg::CNT32_W-1:0] count_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ms_q <= 1'b0;
			filter_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				llh_pkg::REG_UNIT_MS: unit_ms_q <= cfg_data[0];
				llh_pkg::REG_FILTER: filter_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Accepted item.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			icmd_q <= in.command;
			tid_q <= in.thread_id;
			gid_q <= in.group_id;
			ts_q <= in.timestamp_ns;
			op_q <= in.op_type;
			bidx_q <= in.bin_index;
		end
	end

	// Table search: one key read per cycle, compared in the cycle after.
	assign idx = cnt_q[IDX_W-1:0];
	assign issue = cmd.scan_run && (cnt_q < CNT_W'(TABLE_DEPTH));
	assign match = p_s1 && vld_s1 && (key_rd_s1 == tid_q);
	assign last = p_s1 && (idx_s1 == IDX_W'(TABLE_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			p_s1 <= 1'b0;
			free_found_q <= 1'b0;
			found_q <= 1'b0;
		end else if (cmd.load_item) begin
			cnt_q <= '0;
			p_s1 <= 1'b0;
			free_found_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			p_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (!vld_q[idx] && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (cmd.scan_run && (match || last)) begin
				found_q <= match;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
		vld_s1 <= vld_q[idx];
		key_rd_s1 <= key_mem[idx];
		if (issue && !vld_q[idx] && !free_found_q) begin
			free_idx_q <= idx;
		end
		if (cmd.scan_run && (match || last)) begin
			ent_q <= match ? idx_s1 : free_idx_q;
		end
	end

	// Start table storage.
	always_ff @(posedge clk) begin
		if (cmd.wr_entry) begin
			key_mem[ent_q] <= tid_q;
			time_mem[ent_q] <= ts_q;
		end
		if (cmd.rd_time) begin
			time_rd_q <= time_mem[ent_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.wr_entry) begin
			vld_q[ent_q] <= 1'b1;
		end else if (cmd.clr_entry) begin
			vld_q[ent_q] <= 1'b0;
		end
	end

	// Floor log2 of diff/div clamped to 0..BIN_COUNT-1, one step per cycle.
	assign div = unit_ms_q ? llh_pkg::MS_DIV : llh_pkg::US_DIV;

	always_ff @(posedge clk) begin
		if (cmd.calc_diff) begin
			diff_q <= ts_q - time_rd_q;
			thr_q <= {{(llh_pkg::THR_W - llh_pkg::DIV_W){1'b0}}, div} << 1;
			k_q <= '0;
		end else if (cmd.log_step && !sts.log_done) begin
			thr_q <= thr_q << 1;
			k_q <= k_q + llh_pkg::HIT_W'(1);
		end
	end

	// Histogram store with a valid bit per bin standing for the cleared reset value.
	assign bkey = (icmd_q == llh_pkg::CMD_READ) ? bidx_q : k_q;
	assign bsum = BSUM_W'(op_q) * BSUM_W'(BIN_COUNT) + BSUM_W'(bkey);
	assign baddr = bsum[BADDR_W-1:0];
	assign bin_eff = bvld_s1 ? bin_rd_s1 : '0;

	always_ff @(posedge clk) begin
		if (cmd.bin_rd) begin
			bin_rd_s1 <= bin_mem[baddr];
			baddr_q <= baddr;
		end
		if (cmd.bin_wr) begin
			bin_mem[baddr_q] <= bin_eff + llh_pkg::CNT32_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvld_q <= '0;
			bvld_s1 <= 1'b0;
		end else begin
			if (cmd.bin_rd) begin
				bvld_s1 <= bvld_q[baddr];
			end
			if (cmd.bin_wr) begin
				bvld_q[baddr_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			bcount_q <= '0;
		end else if (cmd.bin_wr) begin
			bcount_q <= bin_eff + llh_pkg::CNT32_W'(1);
		end else if (cmd.bin_cap) begin
			bcount_q <= bin_eff;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= cmd.res_code;
			if (cmd.res_code == llh_pkg::ST_BINNED) begin
				hit_q <= k_q;
				count_q <= bcount_q;
			end else if (cmd.res_code == llh_pkg::ST_READ) begin
				hit_q <= bidx_q;
				count_q <= bcount_q;
			end else begin
				hit_q <= '0;
				count_q <= '0;
			end
		end
	end

	assign out.valid = out_valid_q;
	assign out.status = status_q;
	assign out.bin_hit = hit_q;
	assign out.bin_count = count_q;

	always_comb begin
		sts.item_cmd = icmd_q;
		sts.filtered = (filter_q != '0) && (filter_q != gid_q);
		sts.scan_done = match || last;
		sts.found = found_q;
		sts.free_found = free_found_q;
		sts.negative = diff_q[llh_pkg::TS_W-1];
		sts.op_bad = ({1'b0, op_q} >= 4'(OP_TYPES));
		sts.log_done = (k_q == llh_pkg::HIT_W'(BIN_COUNT - 1))
			|| ({{llh_pkg::DIV_W{1'b0}}, diff_q} < thr_q);
		sts.rd_in_range = ({1'b0, op_q} < 4'(OP_TYPES)) && ({1'b0, bidx_q} < 7'(BIN_COUNT));
		sts.out_free = !out_valid_q || out.ready;
	end

endmodule

>>> rtl/llh_ctrl.sv
// Controller: sequences search, table update, binning and histogram access per item.
module llh_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input llh_pkg::ctrl_sts_t sts,
	output llh_pkg::ctrl_cmd_t cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_SCAN = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_SWRITE = 4'd4;
	localparam logic [3:0] S_TREAD = 4'd5;
	localparam logic [3:0] S_TDIFF = 4'd6;
	localparam logic [3:0] S_CHECK = 4'd7;
	localparam logic [3:0] S_LOG = 4'd8;
	localparam logic [3:0] S_BRD = 4'd9;
	localparam logic [3:0] S_BWAIT = 4'd10;
	localparam logic [3:0] S_RESULT = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [llh_pkg::STATUS_W-1:0] code_q;
	logic [llh_pkg::STATUS_W-1:0] code_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		code_d = code_q;
		cmd = '0;
		cmd.res_code = code_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_item = in_valid;
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.item_cmd)
					llh_pkg::CMD_START: begin
						if (sts.filtered) begin
							code_d = llh_pkg::ST_FILTERED;
							state_d = S_RESULT;
						end else begin
							state_d = S_SCAN;
						end
					end
					llh_pkg::CMD_FINISH: state_d = S_SCAN;
					llh_pkg::CMD_READ: begin
						code_d = llh_pkg::ST_READ;
						state_d = sts.rd_in_range ? S_BRD : S_RESULT;
					end
					llh_pkg::CMD_NONE: state_d = S_IDLE;
					default: state_d = S_IDLE;
				endcase
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.item_cmd == llh_pkg::CMD_START) begin
					if (sts.found || sts.free_found) begin
						state_d = S_SWRITE;
					end else begin
						code_d = llh_pkg::ST_FULL;
						state_d = S_RESULT;
					end
				end else if (sts.found) begin
					state_d = S_TREAD;
				end else begin
					code_d = llh_pkg::ST_NO_START;
					state_d = S_RESULT;
				end
			end
			S_SWRITE: begin
				cmd.wr_entry = 1'b1;
				code_d = llh_pkg::ST_STORED;
				state_d = S_RESULT;
			end
			S_TREAD: begin
				cmd.rd_time = 1'b1;
				cmd.clr_entry = 1'b1;
				state_d = S_TDIFF;
			end
			S_TDIFF: begin
				cmd.calc_diff = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				priority if (sts.negative) begin
					code_d = llh_pkg::ST_NEGATIVE;
					state_d = S_RESULT;
				end else if (sts.op_bad) begin
					code_d = llh_pkg::ST_BAD_TYPE;
					state_d = S_RESULT;
				end else begin
					code_d = llh_pkg::ST_BINNED;
					state_d = S_LOG;
				end
			end
			S_LOG: begin
				cmd.log_step = 1'b1;
				if (sts.log_done) begin
					state_d = S_BRD;
				end
			end
			S_BRD: begin
				cmd.bin_rd = 1'b1;
				state_d = S_BWAIT;
			end
			S_BWAIT: begin
				cmd.bin_wr = (code_q == llh_pkg::ST_BINNED);
				cmd.bin_cap = (code_q != llh_pkg::ST_BINNED);
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q <= llh_pkg::ST_STORED;
		end else begin
			state_q <= state_d;
			code_q <= code_d;
		end
	end

endmodule

>>> rtl/latency_log2_histogram.sv
// Top level of the per-thread latency log2 histogram.
//
//   channel  direction  handshake      payload
//   in       sink       valid/ready    command, thread_id, group_id, timestamp_ns,
//                                      op_type, bin_index
//   out      source     valid/ready    status, bin_hit, bin_count
//   cfg      write      cfg_we         cfg_index, cfg_data
//
// One item at a time. An in-range read goes from dispatch through a bin read and a bin
// capture to the result. An unfiltered start or a finish searches the start table one
// entry per cycle through its key memory port, and a binned finish then takes its log2
// steps before the bin update; a match found early in the table ends the search sooner.
// Reset clears the table valid bits and the bin valid bits at once; no clearing pass.
// A stalled result holds in the output register and blocks the next item at its end.
module latency_log2_histogram #(
	parameter int TABLE_DEPTH = llh_pkg::TABLE_DEPTH_DEF,
	parameter int BIN_COUNT = llh_pkg::BIN_COUNT_DEF,
	parameter int OP_TYPES = llh_pkg::OP_TYPES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [llh_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [llh_pkg::CFG_DATA_W-1:0] cfg_data,
	llh_in_if.sink in,
	llh_out_if.source out
);
	llh_pkg::ctrl_cmd_t cmd;
	llh_pkg::ctrl_sts_t sts;

	llh_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in.valid),
		.in_ready(in.ready),
		.sts(sts),
		.cmd(cmd)
	);

	llh_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.BIN_COUNT(BIN_COUNT),
		.OP_TYPES(OP_TYPES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in(in),
		.out(out),
		.cmd(cmd),
		.sts(sts)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in.valid && in.ready) |=> !in.ready)
		else $error("input ready right after an accepted item");
	a_write_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_entry |-> (sts.found || sts.free_found))
		else $error("table write without a matching or free entry");
	a_bin_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bin_wr |-> $past(cmd.bin_rd))
		else $error("bin update without a preceding bin read");
	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> sts.out_free)
		else $error("result loaded over an undelivered item");
`endif

endmodule
